// ===== src/gcei_pkg.sv =====
`default_nettype none
package gcei_pkg;

  localparam int unsigned QW = 32;
  localparam int unsigned TOL_W = 25;
  localparam logic [TOL_W-1:0] TOL_RESET = 25'd5033;

  // operation codes of the sequencer program
  localparam logic [3:0] OP_MOV  = 4'd0;
  localparam logic [3:0] OP_ADD  = 4'd1;
  localparam logic [3:0] OP_SUB  = 4'd2;
  localparam logic [3:0] OP_ABS  = 4'd3;
  localparam logic [3:0] OP_MUL  = 4'd4;
  localparam logic [3:0] OP_DIV  = 4'd5;
  localparam logic [3:0] OP_SQRT = 4'd6;
  localparam logic [3:0] OP_BRP  = 4'd7;
  localparam logic [3:0] OP_JMP  = 4'd8;
  localparam logic [3:0] OP_TEST = 4'd9;
  localparam logic [3:0] OP_END  = 4'd10;

  // register indexes
  localparam logic [3:0] R_QC   = 4'd0;
  localparam logic [3:0] R_E    = 4'd1;
  localparam logic [3:0] R_EM   = 4'd2;
  localparam logic [3:0] R_F    = 4'd3;
  localparam logic [3:0] R_G    = 4'd4;
  localparam logic [3:0] R_Q    = 4'd5;
  localparam logic [3:0] R_A    = 4'd6;
  localparam logic [3:0] R_B    = 4'd7;
  localparam logic [3:0] R_P    = 4'd8;
  localparam logic [3:0] R_T    = 4'd9;
  localparam logic [3:0] R_T2   = 4'd10;
  localparam logic [3:0] R_ONE  = 4'd11;
  localparam logic [3:0] R_PIO2 = 4'd12;
  localparam logic [3:0] R_TOL  = 4'd13;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;
  localparam logic [1:0] ST_CAP  = 2'd3;

  localparam int unsigned PC_W = 6;
  localparam logic [PC_W-1:0] PC_NEG   = 6'd7;
  localparam logic [PC_W-1:0] PC_LOOP  = 6'd23;
  localparam logic [PC_W-1:0] PC_FINAL = 6'd41;

  typedef struct packed {
    logic [3:0]      op;
    logic [3:0]      dst;
    logic [3:0]      s1;
    logic [3:0]      s2;
    logic [PC_W-1:0] tgt;
  } uop_t;

  typedef struct packed {
    logic       load;
    logic       start;
    uop_t       uop;
    logic       emit;
    logic       zero;
    logic [1:0] status;
  } ctl_cmd_t;

  typedef struct packed {
    logic done;
    logic kc_zero;
    logic p_pos;
    logic le;
    logic sat;
  } dp_stat_t;

  function automatic uop_t mk(input logic [3:0] op, input logic [3:0] dst,
                              input logic [3:0] s1, input logic [3:0] s2,
                              input logic [PC_W-1:0] tgt);
    uop_t u;
    u.op = op;
    u.dst = dst;
    u.s1 = s1;
    u.s2 = s2;
    u.tgt = tgt;
    return u;
  endfunction

  function automatic uop_t prog(input logic [PC_W-1:0] pc);
    uop_t u;
    case (pc)
      6'd0:  u = mk(OP_ABS,  R_QC, R_QC,   R_QC, '0);
      6'd1:  u = mk(OP_MOV,  R_E,  R_QC,   R_QC, '0);
      6'd2:  u = mk(OP_MOV,  R_EM, R_ONE,  R_ONE, '0);
      6'd3:  u = mk(OP_BRP,  R_QC, R_QC,   R_QC, PC_NEG);
      // p > 0 start
      6'd4:  u = mk(OP_SQRT, R_P,  R_P,    R_P, '0);
      6'd5:  u = mk(OP_DIV,  R_B,  R_B,    R_P, '0);
      6'd6:  u = mk(OP_JMP,  R_QC, R_QC,   R_QC, PC_LOOP);
      // transformed start
      6'd7:  u = mk(OP_MUL,  R_F,  R_QC,   R_QC, '0);
      6'd8:  u = mk(OP_SUB,  R_Q,  R_ONE,  R_F, '0);
      6'd9:  u = mk(OP_SUB,  R_G,  R_ONE,  R_P, '0);
      6'd10: u = mk(OP_SUB,  R_F,  R_F,    R_P, '0);
      6'd11: u = mk(OP_MUL,  R_T,  R_A,    R_P, '0);
      6'd12: u = mk(OP_SUB,  R_T,  R_B,    R_T, '0);
      6'd13: u = mk(OP_MUL,  R_Q,  R_Q,    R_T, '0);
      6'd14: u = mk(OP_DIV,  R_T,  R_F,    R_G, '0);
      6'd15: u = mk(OP_SQRT, R_P,  R_T,    R_T, '0);
      6'd16: u = mk(OP_SUB,  R_T,  R_A,    R_B, '0);
      6'd17: u = mk(OP_DIV,  R_A,  R_T,    R_G, '0);
      6'd18: u = mk(OP_MUL,  R_T,  R_A,    R_P, '0);
      6'd19: u = mk(OP_MUL,  R_T2, R_G,    R_G, '0);
      6'd20: u = mk(OP_MUL,  R_T2, R_T2,   R_P, '0);
      6'd21: u = mk(OP_DIV,  R_T2, R_Q,    R_T2, '0);
      6'd22: u = mk(OP_SUB,  R_B,  R_T,    R_T2, '0);
      // main loop
      6'd23: u = mk(OP_MOV,  R_F,  R_A,    R_A, '0);
      6'd24: u = mk(OP_DIV,  R_T,  R_B,    R_P, '0);
      6'd25: u = mk(OP_ADD,  R_A,  R_A,    R_T, '0);
      6'd26: u = mk(OP_DIV,  R_G,  R_E,    R_P, '0);
      6'd27: u = mk(OP_MUL,  R_T,  R_F,    R_G, '0);
      6'd28: u = mk(OP_ADD,  R_B,  R_B,    R_T, '0);
      6'd29: u = mk(OP_ADD,  R_B,  R_B,    R_B, '0);
      6'd30: u = mk(OP_ADD,  R_P,  R_G,    R_P, '0);
      6'd31: u = mk(OP_MOV,  R_G,  R_EM,   R_EM, '0);
      6'd32: u = mk(OP_ADD,  R_EM, R_EM,   R_QC, '0);
      6'd33: u = mk(OP_SUB,  R_T,  R_G,    R_QC, '0);
      6'd34: u = mk(OP_ABS,  R_T,  R_T,    R_T, '0);
      6'd35: u = mk(OP_MUL,  R_T2, R_G,    R_TOL, '0);
      6'd36: u = mk(OP_TEST, R_QC, R_QC,   R_QC, PC_FINAL);
      6'd37: u = mk(OP_SQRT, R_QC, R_E,    R_E, '0);
      6'd38: u = mk(OP_ADD,  R_QC, R_QC,   R_QC, '0);
      6'd39: u = mk(OP_MUL,  R_E,  R_QC,   R_EM, '0);
      6'd40: u = mk(OP_JMP,  R_QC, R_QC,   R_QC, PC_LOOP);
      // result
      6'd41: u = mk(OP_MUL,  R_T,  R_A,    R_EM, '0);
      6'd42: u = mk(OP_ADD,  R_T,  R_B,    R_T, '0);
      6'd43: u = mk(OP_MUL,  R_T,  R_PIO2, R_T, '0);
      6'd44: u = mk(OP_ADD,  R_T2, R_EM,   R_P, '0);
      6'd45: u = mk(OP_MUL,  R_T2, R_EM,   R_T2, '0);
      6'd46: u = mk(OP_DIV,  R_T,  R_T,    R_T2, '0);
      default: u = mk(OP_END, R_QC, R_QC,  R_QC, '0);
    endcase
    return u;
  endfunction

endpackage
`default_nettype wire

// ===== src/gcei_dp.sv =====
`default_nettype none
module gcei_dp #(
  parameter int FRAC_BITS = 24
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire gcei_pkg::ctl_cmd_t            cmd,
  input  wire logic signed [31:0]            modulus_comp,
  input  wire logic signed [31:0]            param_p,
  input  wire logic signed [31:0]            coeff_a,
  input  wire logic signed [31:0]            coeff_b,
  input  wire logic [gcei_pkg::TOL_W-1:0]    tol,
  output gcei_pkg::dp_stat_t                 stat,
  output logic [31:0]                        res
);

  localparam int NW = 32 + FRAC_BITS;
  localparam int NP = (32 + FRAC_BITS) / 2;
  localparam int RW = 2 * NP;
  localparam int MW = (NW > 64) ? NW : 64;
  localparam int CW = $clog2(NW + 1);
  localparam logic [63:0] PIO2_Q60 = 64'h1921FB54442D1847;
  localparam logic [63:0] PIO2_RAW =
    (PIO2_Q60 + (64'd1 << (59 - FRAC_BITS))) >> (60 - FRAC_BITS);
  localparam logic [31:0] ONE_C = (FRAC_BITS >= 31) ? 32'h7FFFFFFF : 32'(64'd1 << FRAC_BITS);
  localparam logic [31:0] PIO2_C = (PIO2_RAW > 64'h7FFFFFFF) ? 32'h7FFFFFFF : PIO2_RAW[31:0];
  localparam logic CONST_SAT = (FRAC_BITS >= 31);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_MUL  = 2'd1;
  localparam logic [1:0] PH_DIV  = 2'd2;
  localparam logic [1:0] PH_SQRT = 2'd3;

  logic [31:0] qc, e, em, f, g, q, a, b, p, t, t2;
  logic        sat, kc_zero, p_pos, done;
  logic [1:0]  phase;
  logic [3:0]  dst;
  logic        neg;
  logic [63:0] prod;
  logic [NW-1:0] nq;
  logic [31:0] rem;
  logic [31:0] dvs;
  logic [RW-1:0] rad;
  logic [NP+1:0] srem;
  logic [NP-1:0] root;
  logic [CW-1:0] cnt;

  function automatic logic [32:0] fm(input logic [MW-1:0] m, input logic ng);
    logic [MW-1:0] lim_n, lim_p;
    lim_n = {{(MW-32){1'b0}}, 32'h80000000};
    lim_p = {{(MW-32){1'b0}}, 32'h7FFFFFFF};
    if (ng) begin
      if (m > lim_n) return {1'b1, 32'h80000000};
      return {1'b0, 32'(-m[31:0])};
    end
    if (m > lim_p) return {1'b1, 32'h7FFFFFFF};
    return {1'b0, m[31:0]};
  endfunction

  function automatic logic [32:0] sat33(input logic [32:0] s);
    if (s[32] != s[31]) return {1'b1, s[32] ? 32'h80000000 : 32'h7FFFFFFF};
    return {1'b0, s[31:0]};
  endfunction

  function automatic logic [31:0] rd(input logic [3:0] idx, input logic [31:0] r_qc,
      input logic [31:0] r_e, input logic [31:0] r_em, input logic [31:0] r_f,
      input logic [31:0] r_g, input logic [31:0] r_q, input logic [31:0] r_a,
      input logic [31:0] r_b, input logic [31:0] r_p, input logic [31:0] r_t,
      input logic [31:0] r_t2, input logic [31:0] r_tol);
    case (idx)
      gcei_pkg::R_QC:   return r_qc;
      gcei_pkg::R_E:    return r_e;
      gcei_pkg::R_EM:   return r_em;
      gcei_pkg::R_F:    return r_f;
      gcei_pkg::R_G:    return r_g;
      gcei_pkg::R_Q:    return r_q;
      gcei_pkg::R_A:    return r_a;
      gcei_pkg::R_B:    return r_b;
      gcei_pkg::R_P:    return r_p;
      gcei_pkg::R_T:    return r_t;
      gcei_pkg::R_T2:   return r_t2;
      gcei_pkg::R_ONE:  return ONE_C;
      gcei_pkg::R_PIO2: return PIO2_C;
      gcei_pkg::R_TOL:  return r_tol;
      default:          return 32'd0;
    endcase
  endfunction

  logic [31:0] x, y, mx, my;
  logic [32:0] simple;
  logic [32:0] wres;
  logic        wen;
  logic [32:0] rem2;
  logic        dge;
  logic [NW-1:0] nq_n;
  logic [NP+3:0] sremc, strial;
  logic        sge;
  logic [NP-1:0] root_n;
  logic [MW-1:0] sq_m, dv_m, mu_m;

  assign x = rd(cmd.uop.s1, qc, e, em, f, g, q, a, b, p, t, t2,
                {{(32-gcei_pkg::TOL_W){1'b0}}, tol});
  assign y = rd(cmd.uop.s2, qc, e, em, f, g, q, a, b, p, t, t2,
                {{(32-gcei_pkg::TOL_W){1'b0}}, tol});
  assign mx = x[31] ? 32'(-x) : x;
  assign my = y[31] ? 32'(-y) : y;

  always_comb begin
    case (cmd.uop.op)
      gcei_pkg::OP_ADD: simple = sat33({x[31], x} + {y[31], y});
      gcei_pkg::OP_SUB: simple = sat33({x[31], x} - {y[31], y});
      gcei_pkg::OP_ABS: simple = x[31] ? sat33(33'd0 - {x[31], x}) : {1'b0, x};
      default:          simple = {1'b0, x};
    endcase
  end

  // long division step: one quotient bit per cycle
  assign rem2 = {rem, nq[NW-1]};
  assign dge = rem2 >= {1'b0, dvs};
  assign nq_n = {nq[NW-2:0], dge};

  // square root step: one radicand bit pair per cycle
  assign sremc = {srem, rad[RW-1:RW-2]};
  assign strial = {2'b00, root, 2'b01};
  assign sge = sremc >= strial;
  assign root_n = {root[NP-2:0], sge};

  assign mu_m = MW'(prod >> FRAC_BITS);
  assign dv_m = MW'(nq_n);
  assign sq_m = MW'(root_n);

  always_comb begin
    wen = 1'b0;
    wres = '0;
    case (phase)
      PH_MUL: begin
        wen = 1'b1;
        wres = fm(mu_m, neg);
      end
      PH_DIV: begin
        if (cnt == CW'(1)) begin
          wen = 1'b1;
          wres = fm(dv_m, neg);
        end
      end
      PH_SQRT: begin
        if (cnt == CW'(1)) begin
          wen = 1'b1;
          wres = fm(sq_m, 1'b0);
        end
      end
      default: begin
        if (cmd.start) begin
          case (cmd.uop.op)
            gcei_pkg::OP_MUL, gcei_pkg::OP_DIV, gcei_pkg::OP_SQRT: begin
              if (cmd.uop.op == gcei_pkg::OP_DIV && my == 32'd0) begin
                wen = 1'b1;
                wres = {1'b1, (x == 32'd0) ? 32'd0 : (x[31] ? 32'h80000000 : 32'h7FFFFFFF)};
              end else if (cmd.uop.op == gcei_pkg::OP_SQRT && (x[31] || x == 32'd0)) begin
                wen = 1'b1;
                wres = {x[31], 32'd0};
              end
            end
            default: begin
              wen = 1'b1;
              wres = simple;
            end
          endcase
        end
      end
    endcase
  end

  logic [3:0] wdst;
  assign wdst = (phase == PH_IDLE) ? cmd.uop.dst : dst;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      done <= 1'b0;
      sat <= 1'b0;
    end else begin
      done <= wen;
      if (cmd.load) begin
        qc <= modulus_comp;
        a <= coeff_a;
        b <= coeff_b;
        p <= param_p;
        kc_zero <= (modulus_comp == 32'sd0);
        p_pos <= (param_p > 32'sd0);
        sat <= CONST_SAT;
      end
      if (wen) begin
        sat <= sat | wres[32];
        case (wdst)
          gcei_pkg::R_QC: qc <= wres[31:0];
          gcei_pkg::R_E:  e <= wres[31:0];
          gcei_pkg::R_EM: em <= wres[31:0];
          gcei_pkg::R_F:  f <= wres[31:0];
          gcei_pkg::R_G:  g <= wres[31:0];
          gcei_pkg::R_Q:  q <= wres[31:0];
          gcei_pkg::R_A:  a <= wres[31:0];
          gcei_pkg::R_B:  b <= wres[31:0];
          gcei_pkg::R_P:  p <= wres[31:0];
          gcei_pkg::R_T:  t <= wres[31:0];
          gcei_pkg::R_T2: t2 <= wres[31:0];
          default: ;
        endcase
      end
      case (phase)
        PH_MUL: phase <= PH_IDLE;
        PH_DIV: begin
          nq <= nq_n;
          rem <= dge ? 32'(rem2 - {1'b0, dvs}) : rem2[31:0];
          cnt <= cnt - CW'(1);
          if (cnt == CW'(1)) phase <= PH_IDLE;
        end
        PH_SQRT: begin
          rad <= {rad[RW-3:0], 2'b00};
          srem <= sge ? (NP+2)'(sremc - strial) : sremc[NP+1:0];
          root <= root_n;
          cnt <= cnt - CW'(1);
          if (cnt == CW'(1)) phase <= PH_IDLE;
        end
        default: begin
          if (cmd.start && !wen) begin
            dst <= cmd.uop.dst;
            neg <= x[31] ^ y[31];
            case (cmd.uop.op)
              gcei_pkg::OP_MUL: begin
                prod <= 64'(mx) * 64'(my);
                phase <= PH_MUL;
              end
              gcei_pkg::OP_DIV: begin
                nq <= {mx, {FRAC_BITS{1'b0}}};
                rem <= 32'd0;
                dvs <= my;
                cnt <= CW'(NW);
                phase <= PH_DIV;
              end
              default: begin
                rad <= RW'({x, {FRAC_BITS{1'b0}}});
                srem <= '0;
                root <= '0;
                cnt <= CW'(NP);
                phase <= PH_SQRT;
              end
            endcase
          end
        end
      endcase
    end
  end

  assign stat.done = done;
  assign stat.kc_zero = kc_zero;
  assign stat.p_pos = p_pos;
  assign stat.le = $signed(t) <= $signed(t2);
  assign stat.sat = sat;
  assign res = t;

endmodule
`default_nettype wire

// ===== src/gcei_ctrl.sv =====
`default_nettype none
module gcei_ctrl #(
  parameter int MAX_ITER = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                out_busy,
  input  wire logic                out_ready,
  input  wire gcei_pkg::dp_stat_t  stat,
  output gcei_pkg::ctl_cmd_t       cmd
);

  localparam int NCW = $clog2(MAX_ITER + 1);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_ISSUE = 3'd2;
  localparam logic [2:0] S_WAIT  = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0] state, state_next;
  logic [gcei_pkg::PC_W-1:0] pc, pc_next;
  logic [NCW-1:0] n, n_next;
  logic capped, capped_next;
  gcei_pkg::uop_t uop;

  assign uop = gcei_pkg::prog(pc);

  always_comb begin
    state_next = state;
    pc_next = pc;
    n_next = n;
    capped_next = capped;
    in_ready = 1'b0;
    cmd = '0;
    cmd.uop = uop;
    cmd.zero = stat.kc_zero;
    cmd.status = stat.kc_zero ? gcei_pkg::ST_ZERO :
                 stat.sat ? gcei_pkg::ST_SAT :
                 capped ? gcei_pkg::ST_CAP : gcei_pkg::ST_OK;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        pc_next = '0;
        n_next = NCW'(1);
        capped_next = 1'b0;
        state_next = stat.kc_zero ? S_EMIT : S_ISSUE;
      end
      S_ISSUE: begin
        case (uop.op)
          gcei_pkg::OP_BRP: pc_next = stat.p_pos ? pc + 1'b1 : uop.tgt;
          gcei_pkg::OP_JMP: pc_next = uop.tgt;
          gcei_pkg::OP_TEST: begin
            if (stat.le) begin
              pc_next = uop.tgt;
            end else if (n >= NCW'(MAX_ITER)) begin
              capped_next = 1'b1;
              pc_next = uop.tgt;
            end else begin
              n_next = n + 1'b1;
              pc_next = pc + 1'b1;
            end
          end
          gcei_pkg::OP_END: state_next = S_EMIT;
          default: begin
            cmd.start = 1'b1;
            state_next = S_WAIT;
          end
        endcase
      end
      S_WAIT: begin
        if (stat.done) begin
          pc_next = pc + 1'b1;
          state_next = S_ISSUE;
        end
      end
      S_EMIT: begin
        if (!out_busy || out_ready) begin
          cmd.emit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pc <= '0;
      n <= '0;
      capped <= 1'b0;
    end else begin
      state <= state_next;
      pc <= pc_next;
      n <= n_next;
      capped <= capped_next;
    end
  end

endmodule
`default_nettype wire

// ===== src/general_complete_elliptic_integral_core.sv =====
`default_nettype none
// channel   signals                                         direction
// in        in_valid in_ready modulus_comp param_p coeff_a coeff_b   into core
// out       out_valid out_ready integral_value status          out of core
// cfg       cfg_valid cfg_ready cfg_data (tolerance)           into core
//
// one transaction at a time; a sequencer steps a micro-program through one shared
// datapath: a divide or square root runs as an iterative loop, a multiply goes through a
// product register, other arithmetic writes back directly, a branch is taken in the sequencer
// the main loop runs up to MAX_ITER passes after the p > 0 start or, otherwise, the
// transformed start; a zero modulus skips the program
// reset loads the tolerance default and empties the result register
// a held result stalls only the end of the next transaction, not its acceptance
module general_complete_elliptic_integral_core #(
  parameter int MAX_ITER = 16,
  parameter int FRAC_BITS = 24
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic signed [31:0]          modulus_comp,
  input  wire logic signed [31:0]          param_p,
  input  wire logic signed [31:0]          coeff_a,
  input  wire logic signed [31:0]          coeff_b,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic signed [31:0]               integral_value,
  output logic [1:0]                       status,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [gcei_pkg::TOL_W-1:0]  cfg_data
);

  logic [gcei_pkg::TOL_W-1:0] tol;
  gcei_pkg::ctl_cmd_t cmd;
  gcei_pkg::dp_stat_t stat;
  logic [31:0] res;

  assign cfg_ready = 1'b1;

  gcei_ctrl #(.MAX_ITER(MAX_ITER)) u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_busy(out_valid), .out_ready(out_ready), .stat(stat), .cmd(cmd)
  );

  gcei_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .modulus_comp(modulus_comp),
    .param_p(param_p), .coeff_a(coeff_a), .coeff_b(coeff_b), .tol(tol),
    .stat(stat), .res(res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= gcei_pkg::TOL_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) tol <= cfg_data;
      if (cmd.emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      integral_value <= cmd.zero ? 32'sd0 : $signed(res);
      status <= cmd.status;
    end
  end

endmodule
`default_nettype wire
